// File: rtl/mavg_pkg.sv
// Shared constants for the moving average window block.
// No dependencies; imported by every module of the block.
`default_nettype none

package mavg_pkg;

  // Default window length in samples
  localparam int unsigned DefWindow = 64;

  // Fixed field widths
  localparam int unsigned SampleW = 16;
  localparam int unsigned CountOutW = 7;

  // Action codes of an input item
  localparam logic ActPush = 1'b0;
  localparam logic ActClear = 1'b1;

endpackage

`default_nettype wire

// File: rtl/moving_average_window.sv
// Boxcar moving average over the last WINDOW signed samples.
// Input queue port: push_i with action_i/sample_i; transfer when push_i is high and full_o low.
// Result queue port: average_o/valid_count_o show the oldest result while empty_o is low;
//   transfer when pop_i is high and empty_o low.
// action_i low pushes a sample and returns sum / count truncated toward zero;
//   action_i high clears the window and returns zero with a count of zero.
// Front end handles each item as a transfer, then a ring read and sum update, and
//   feeds a two-entry queue; it takes no new item while updating. The divider works on
//   SumW-bit sums (SumW = 16 + log2(WINDOW), 22 at the default), one quotient bit per cycle,
//   and takes no new item until its result has moved to the output register.
// A stalled result waits in the output register; the divider and queue keep
//   filling behind it, and full_o rises once they are all occupied.
// Reset clears sum, position, count and all valid flags; the ring is not cleared,
//   since no slot is read before it has been written.
// Depends on mavg_pkg, mavg_front, mavg_queue and mavg_div.
`default_nettype none

module moving_average_window import mavg_pkg::*; #(
  parameter int unsigned WINDOW = DefWindow
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                push_i,
  output logic                     full_o,
  input  wire logic                action_i,
  input  wire logic [SampleW-1:0]  sample_i,
  output logic                     empty_o,
  input  wire logic                pop_i,
  output logic [SampleW-1:0]       average_o,
  output logic [CountOutW-1:0]     valid_count_o
);

  localparam int unsigned CntW = $clog2(WINDOW + 1);
  localparam int unsigned SumW = SampleW + $clog2(WINDOW);
  localparam int unsigned EntryW = SumW + CntW;

  logic              fq_push, fq_full;
  logic [SumW-1:0]   fq_sum, bq_sum;
  logic [CntW-1:0]   fq_count, bq_count;
  logic              bq_valid, bq_pop;
  logic [EntryW-1:0] bq_data;

  // Accept items and update window state
  mavg_front #(.WINDOW(WINDOW)) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (push_i),
    .full_o    (full_o),
    .action_i  (action_i),
    .sample_i  (sample_i),
    .q_push_o  (fq_push),
    .q_full_i  (fq_full),
    .q_sum_o   (fq_sum),
    .q_count_o (fq_count)
  );

  // Decouple front end from divider
  mavg_queue #(.DataW(EntryW)) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (fq_push),
    .full_o  (fq_full),
    .data_i  ({fq_sum, fq_count}),
    .valid_o (bq_valid),
    .pop_i   (bq_pop),
    .data_o  (bq_data)
  );

  assign bq_sum = bq_data[EntryW-1:CntW];
  assign bq_count = bq_data[CntW-1:0];

  // Divide and present results
  mavg_div #(.WINDOW(WINDOW)) u_div (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .q_valid_i     (bq_valid),
    .q_pop_o       (bq_pop),
    .q_sum_i       (bq_sum),
    .q_count_i     (bq_count),
    .empty_o       (empty_o),
    .pop_i         (pop_i),
    .average_o     (average_o),
    .valid_count_o (valid_count_o)
  );

endmodule

`default_nettype wire

// File: rtl/mavg_front.sv
// Front end: accepts items, keeps the sample ring, running sum, position and fill count.
// Depends on mavg_pkg; hands (sum, count) pairs to the queue toward the divider.
`default_nettype none

module mavg_front import mavg_pkg::*; #(
  parameter int unsigned WINDOW = DefWindow,
  localparam int unsigned PosW = $clog2(WINDOW),
  localparam int unsigned CntW = $clog2(WINDOW + 1),
  localparam int unsigned SumW = SampleW + $clog2(WINDOW)
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                push_i,
  output logic                     full_o,
  input  wire logic                action_i,
  input  wire logic [SampleW-1:0]  sample_i,
  output logic                     q_push_o,
  input  wire logic                q_full_i,
  output logic [SumW-1:0]          q_sum_o,
  output logic [CntW-1:0]          q_count_o
);

  typedef enum logic {FIdle, FExec} fstate_e;

  fstate_e              state_q;
  logic                 act_q;
  logic [SampleW-1:0]   smp_q;
  logic [SampleW-1:0]   old_q;
  logic [SampleW-1:0]   ring_q [WINDOW];
  logic [SumW-1:0]      sum_q, sum_d;
  logic [PosW-1:0]      wpos_q, wpos_d;
  logic [CntW-1:0]      cnt_q, cnt_d;
  logic                 accept;
  logic                 win_full;
  logic [SumW-1:0]      smp_ext, old_ext;

  assign full_o = (state_q == FExec) || q_full_i;
  assign accept = push_i && !full_o;
  assign win_full = (cnt_q == CntW'(WINDOW));

  assign smp_ext = {{(SumW-SampleW){smp_q[SampleW-1]}}, smp_q};
  assign old_ext = {{(SumW-SampleW){old_q[SampleW-1]}}, old_q};

  // Compute next sum, position and count for the item in execution
  always_comb begin
    sum_d = sum_q;
    wpos_d = wpos_q;
    cnt_d = cnt_q;
    if (act_q == ActClear) begin
      sum_d = '0;
      wpos_d = '0;
      cnt_d = '0;
    end else begin
      sum_d = sum_q + smp_ext - (win_full ? old_ext : '0);
      if (!win_full) begin
        cnt_d = cnt_q + 1'b1;
      end
      if (wpos_q == PosW'(WINDOW - 1)) begin
        wpos_d = '0;
      end else begin
        wpos_d = wpos_q + 1'b1;
      end
    end
  end

  // Hand the updated pair to the queue in the execute cycle
  assign q_push_o = (state_q == FExec);
  assign q_sum_o = sum_d;
  assign q_count_o = cnt_d;

  // Ring storage: read the slot at the write position, write it on a push
  always_ff @(posedge clk_i) begin
    old_q <= ring_q[wpos_q];
    if (state_q == FExec && act_q == ActPush) begin
      ring_q[wpos_q] <= smp_q;
    end
  end

  // Capture the item on transfer
  always_ff @(posedge clk_i) begin
    if (accept) begin
      act_q <= action_i;
      smp_q <= sample_i;
    end
  end

  // Control state and window bookkeeping
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= FIdle;
      sum_q <= '0;
      wpos_q <= '0;
      cnt_q <= '0;
    end else begin
      unique case (state_q)
        FIdle: begin
          if (accept) begin
            state_q <= FExec;
          end
        end
        FExec: begin
          sum_q <= sum_d;
          wpos_q <= wpos_d;
          cnt_q <= cnt_d;
          state_q <= FIdle;
        end
        default: state_q <= FIdle;
      endcase
    end
  end

endmodule

`default_nettype wire

// File: rtl/mavg_queue.sv
// Two-entry queue between the front end and the divider.
// Depends on mavg_pkg for the default width SampleW; width is a parameter.
`default_nettype none

module mavg_queue import mavg_pkg::*; #(
  parameter int unsigned DataW = SampleW
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              push_i,
  output logic                   full_o,
  input  wire logic [DataW-1:0]  data_i,
  output logic                   valid_o,
  input  wire logic              pop_i,
  output logic [DataW-1:0]       data_o
);

  logic [DataW-1:0] buf_q [2];
  logic             wr_q, rd_q;
  logic [1:0]       cnt_q;
  logic             do_push, do_pop;

  assign full_o = (cnt_q == 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign do_push = push_i && !full_o;
  assign do_pop = pop_i && valid_o;
  assign data_o = buf_q[rd_q];

  // Store an entry on push
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      buf_q[wr_q] <= data_i;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q <= 1'b0;
      rd_q <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (do_push) begin
        wr_q <= ~wr_q;
      end
      if (do_pop) begin
        rd_q <= ~rd_q;
      end
      unique case ({do_push, do_pop})
        2'b10: cnt_q <= cnt_q + 2'd1;
        2'b01: cnt_q <= cnt_q - 2'd1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

`default_nettype wire

// File: rtl/mavg_div.sv
// Back end: divides the running sum by the fill count, one quotient bit per cycle.
// Depends on mavg_pkg; holds the finished result in an output register.
`default_nettype none

module mavg_div import mavg_pkg::*; #(
  parameter int unsigned WINDOW = DefWindow,
  localparam int unsigned CntW = $clog2(WINDOW + 1),
  localparam int unsigned SumW = SampleW + $clog2(WINDOW),
  localparam int unsigned StepW = $clog2(SumW)
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 q_valid_i,
  output logic                      q_pop_o,
  input  wire logic [SumW-1:0]      q_sum_i,
  input  wire logic [CntW-1:0]      q_count_i,
  output logic                      empty_o,
  input  wire logic                 pop_i,
  output logic [SampleW-1:0]        average_o,
  output logic [CountOutW-1:0]      valid_count_o
);

  typedef enum logic [1:0] {BIdle, BDivide, BHold} bstate_e;

  bstate_e              state_q;
  logic                 out_valid_q;
  logic [SampleW-1:0]   avg_q;
  logic [CountOutW-1:0] vcnt_q;
  logic                 neg_q;
  logic [SumW-1:0]      quo_q;
  logic [CntW:0]        rem_q;
  logic [CntW-1:0]      div_q;
  logic [StepW-1:0]     step_q;
  logic [CntW:0]        rem_shift, rem_diff;
  logic [SumW-1:0]      quo_next, quo_signed;
  logic [CntW+CountOutW-1:0] cnt_wide;
  logic                 out_free;

  assign empty_o = !out_valid_q;
  assign average_o = avg_q;
  assign valid_count_o = vcnt_q;
  assign q_pop_o = (state_q == BIdle) && q_valid_i;
  assign out_free = !out_valid_q || pop_i;
  assign cnt_wide = {{CountOutW{1'b0}}, div_q};

  // One restoring step: shift in the next dividend bit, subtract if it fits
  always_comb begin
    rem_shift = {rem_q[CntW-1:0], quo_q[SumW-1]};
    rem_diff = rem_shift - {1'b0, div_q};
    quo_next = {quo_q[SumW-2:0], ~rem_diff[CntW]};
  end

  // Restore the sign of the quotient
  assign quo_signed = neg_q ? (~quo_q + 1'b1) : quo_q;

  // Sequencer, datapath and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= BIdle;
      out_valid_q <= 1'b0;
      avg_q <= '0;
      vcnt_q <= '0;
      neg_q <= 1'b0;
      quo_q <= '0;
      rem_q <= '0;
      div_q <= '0;
      step_q <= '0;
    end else begin
      // drop the result once it has been transferred, unless a new one replaces it
      if (pop_i && out_valid_q && (state_q != BHold)) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        BIdle: begin
          if (q_valid_i) begin
            rem_q <= '0;
            div_q <= q_count_i;
            step_q <= '0;
            if (q_count_i == '0) begin
              // empty window: quotient is zero
              neg_q <= 1'b0;
              quo_q <= '0;
              state_q <= BHold;
            end else begin
              neg_q <= q_sum_i[SumW-1];
              quo_q <= q_sum_i[SumW-1] ? (~q_sum_i + 1'b1) : q_sum_i;
              state_q <= BDivide;
            end
          end
        end
        BDivide: begin
          quo_q <= quo_next;
          if (!rem_diff[CntW]) begin
            rem_q <= rem_diff;
          end else begin
            rem_q <= rem_shift;
          end
          step_q <= step_q + 1'b1;
          if (step_q == StepW'(SumW - 1)) begin
            state_q <= BHold;
          end
        end
        BHold: begin
          if (out_free) begin
            avg_q <= quo_signed[SampleW-1:0];
            vcnt_q <= cnt_wide[CountOutW-1:0];
            out_valid_q <= 1'b1;
            state_q <= BIdle;
          end
        end
        default: state_q <= BIdle;
      endcase
    end
  end

endmodule

`default_nettype wire
